[rtl/rtb_pkg.sv]
// Shared types, constants and helper functions of the ranging timing budget block.
// Used by every module under rtl; no dependencies.
package rtb_pkg;

  localparam int REQ_W  = 22;
  localparam int BUD_W  = 32;
  localparam int CODE_W = 16;
  localparam int NS_W   = 20;
  localparam int US_W   = 23;
  localparam int DIV_W  = 32;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 16;

  localparam logic [CIDX_W-1:0] CFG_SEQ       = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PRE_PER   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_FIN_PER   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_MSRC_TO   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_PRE_TO    = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_FIN_TO    = 3'd5;

  localparam logic [BUD_W-1:0] START_GET = 32'd2870;
  localparam logic [BUD_W-1:0] START_SET = 32'd2280;
  localparam logic [BUD_W-1:0] COST_TCC  = 32'd590;
  localparam logic [BUD_W-1:0] COST_DSS  = 32'd690;
  localparam logic [BUD_W-1:0] COST_MSRC = 32'd660;
  localparam logic [BUD_W-1:0] COST_PRE  = 32'd660;
  localparam logic [BUD_W-1:0] COST_FIN  = 32'd550;
  localparam logic [BUD_W-1:0] BUDGET_MIN = 32'd20000;

  // ns = 3813*pclks + (120*pclks + 500)/1000
  localparam logic [NS_W-1:0] NS_MUL = 20'd3813;
  // floor(x/1000) = (x * RECIP) >> RECIP_SH, exact for 32-bit x
  localparam logic [28:0] RECIP    = 29'd274877907;
  localparam int          RECIP_SH = 38;

  localparam int SEQ_MSRC = 2;
  localparam int SEQ_DSS  = 3;
  localparam int SEQ_TCC  = 4;
  localparam int SEQ_PRE  = 6;
  localparam int SEQ_FIN  = 7;

  typedef struct packed {
    logic [7:0]  seq;
    logic [7:0]  pre_per;
    logic [7:0]  fin_per;
    logic [7:0]  msrc_to;
    logic [15:0] pre_to;
    logic [15:0] fin_to;
  } rtb_cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [US_W-1:0]   msrc_us;
    logic [US_W-1:0]   pre_us;
    logic [US_W-1:0]   fin_us;
    logic [CODE_W-1:0] pre_m;
    logic [NS_W-1:0]   ns_fin;
  } rtb_times_t;

  typedef struct packed {
    logic [BUD_W-1:0]  budget;
    logic              ok;
    logic              wr;
    logic [CODE_W-1:0] pre_m;
  } rtb_side_t;

  function automatic logic [7:0] period_pclks(input logic [7:0] c);
    logic [7:0] c1;
    c1 = c + 8'd1;
    return {c1[6:0], 1'b0};
  endfunction

  function automatic logic [NS_W-1:0] pclk_period_ns(input logic [7:0] p);
    logic [NS_W-1:0] base;
    logic [14:0]     v;
    logic [4:0]      t;
    base = NS_MUL * NS_W'(p);
    v = 15'd120 * 15'(p) + 15'd500;
    t = '0;
    for (int k = 1; k <= 30; k++) begin
      if (v >= 15'(1000 * k)) t = t + 5'd1;
    end
    return base + NS_W'(t);
  endfunction

  function automatic logic [CODE_W-1:0] decode_code(input logic [15:0] c);
    logic [15:0] sh;
    sh = {8'd0, c[7:0]} << c[11:8];
    if (c[15:8] >= 8'd16) return 16'd1;
    return sh + 16'd1;
  endfunction

  function automatic logic [CODE_W-1:0] encode_code(input logic [15:0] m);
    logic [15:0] mm;
    logic [3:0]  e;
    logic [15:0] man;
    mm = m - 16'd1;
    e = '0;
    for (int i = 8; i < 16; i++) begin
      if (mm[i]) e = 4'(i - 7);
    end
    man = mm >> e;
    if (m == 16'd0) return 16'd0;
    return {4'd0, e, man[7:0]};
  endfunction

endpackage

[rtl/rtb_if.sv]
// Valid/ready channels of the ranging timing budget block.
// Depends on rtb_pkg for field widths.
interface rtb_req_if;
  import rtb_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] requested_budget_us;
  modport source (output valid, output requested_budget_us, input ready);
  modport sink   (input valid, input requested_budget_us, output ready);
endinterface

interface rtb_res_if;
  import rtb_pkg::*;
  logic              valid;
  logic              ready;
  logic [BUD_W-1:0]  current_budget_us;
  logic              accepted;
  logic              timeout_valid;
  logic [CODE_W-1:0] new_final_code;
  modport source (output valid, output current_budget_us, output accepted,
                  output timeout_valid, output new_final_code, input ready);
  modport sink   (input valid, input current_budget_us, input accepted,
                  input timeout_valid, input new_final_code, output ready);
endinterface

[rtl/rtb_steps.sv]
// Three-stage front end: periods, decoded timeouts, step times in microseconds.
// Depends on rtb_pkg.
module rtb_steps (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [rtb_pkg::REQ_W-1:0] in_req,
  input  rtb_pkg::rtb_cfg_t   cfg,
  output logic                out_valid,
  output rtb_pkg::rtb_times_t out_times
);
  import rtb_pkg::*;

  logic v1, v2;
  logic [REQ_W-1:0]  req1, req2;
  logic [NS_W-1:0]   nsp1, nsf1, nsf2;
  logic [8:0]        mm1;
  logic [CODE_W-1:0] mp1, mf1, mp2;
  logic [BUD_W-1:0]  xm2, xp2, xf2;

  logic [CODE_W-1:0] dec_pre, dec_fin;
  logic [NS_W-1:0]   ns_pre, ns_fin;
  logic [35:0]       pm, pp, pf;
  logic [60:0]       rm, rp, rf;

  always_comb begin
    ns_pre  = pclk_period_ns(period_pclks(cfg.pre_per));
    ns_fin  = pclk_period_ns(period_pclks(cfg.fin_per));
    dec_pre = decode_code(cfg.pre_to);
    dec_fin = decode_code(cfg.fin_to);
    if (cfg.seq[SEQ_PRE]) dec_fin = dec_fin - dec_pre;
    pm = 36'(mm1) * 36'(nsp1);
    pp = 36'(mp1) * 36'(nsp1);
    pf = 36'(mf1) * 36'(nsf1);
    rm = 61'(xm2) * 61'(RECIP);
    rp = 61'(xp2) * 61'(RECIP);
    rf = 61'(xf2) * 61'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (adv) begin
      req1 <= in_req;
      nsp1 <= ns_pre;
      nsf1 <= ns_fin;
      mm1  <= {1'b0, cfg.msrc_to} + 9'd1;
      mp1  <= dec_pre;
      mf1  <= dec_fin;
      req2 <= req1;
      nsf2 <= nsf1;
      mp2  <= mp1;
      xm2  <= pm[31:0] + BUD_W'(nsp1 >> 1);
      xp2  <= pp[31:0] + BUD_W'(nsp1 >> 1);
      xf2  <= pf[31:0] + BUD_W'(nsf1 >> 1);
      out_times.req     <= req2;
      out_times.pre_m   <= mp2;
      out_times.ns_fin  <= nsf2;
      out_times.msrc_us <= rm[60:RECIP_SH];
      out_times.pre_us  <= rp[60:RECIP_SH];
      out_times.fin_us  <= rf[60:RECIP_SH];
    end
  end

endmodule

[rtl/rtb_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on rtb_pkg.
module rtb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_valid,
  input  logic [rtb_pkg::DIV_W-1:0] in_num,
  input  logic [rtb_pkg::NS_W-1:0]  in_den,
  input  rtb_pkg::rtb_side_t        in_side,
  output logic                      out_valid,
  output logic [rtb_pkg::DIV_W-1:0] out_quo,
  output rtb_pkg::rtb_side_t        out_side
);
  import rtb_pkg::*;

  logic [DIV_W-1:0] nq  [0:DIV_W];
  logic [NS_W-1:0]  rem [0:DIV_W];
  logic [NS_W-1:0]  den [0:DIV_W];
  rtb_side_t        sd  [0:DIV_W];
  logic             vld [0:DIV_W];

  assign nq[0]  = in_num;
  assign rem[0] = '0;
  assign den[0] = in_den;
  assign sd[0]  = in_side;
  assign vld[0] = in_valid;

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [NS_W:0] sh, df;
    logic          ge;
    always_comb begin
      sh = {rem[k], nq[k][DIV_W-1]};
      ge = sh >= {1'b0, den[k]};
      df = sh - {1'b0, den[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (adv) vld[k+1] <= vld[k];
      if (adv) begin
        rem[k+1] <= ge ? df[NS_W-1:0] : sh[NS_W-1:0];
        nq[k+1]  <= {nq[k][DIV_W-2:0], ge};
        den[k+1] <= den[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign out_valid = vld[DIV_W];
  assign out_quo   = nq[DIV_W];
  assign out_side  = sd[DIV_W];

endmodule

[rtl/ranging_timing_budget_calc.sv]
// Ranging timing budget calculator: one result word per request word.
// The path from request accept to result valid runs through 3 front-end stages,
// 2 budget stages, 32 divider stages and 1 output register; one word per cycle unless stalled.
// The whole pipeline advances together and holds while the result is stalled.
// Synchronous reset clears valid bits and loads the register reset values.
module ranging_timing_budget_calc (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rtb_pkg::CIDX_W-1:0] cfg_index,
  input  logic [rtb_pkg::CDAT_W-1:0] cfg_wdata,
  rtb_req_if.sink                    req,
  rtb_res_if.source                  res
);
  import rtb_pkg::*;

  rtb_cfg_t cfg;
  logic     adv;

  // Whole-pipeline enable: advance whenever the output slot is free or taken.
  assign adv       = !res.valid || res.ready;
  assign req.ready = adv;

  // Configuration registers; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seq     <= 8'd232;
      cfg.pre_per <= 8'd6;
      cfg.fin_per <= 8'd4;
      cfg.msrc_to <= 8'd37;
      cfg.pre_to  <= 16'd150;
      cfg.fin_to  <= 16'd510;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEQ:     cfg.seq     <= cfg_wdata[7:0];
        CFG_PRE_PER: cfg.pre_per <= cfg_wdata[7:0];
        CFG_FIN_PER: cfg.fin_per <= cfg_wdata[7:0];
        CFG_MSRC_TO: cfg.msrc_to <= cfg_wdata[7:0];
        CFG_PRE_TO:  cfg.pre_to  <= cfg_wdata;
        CFG_FIN_TO:  cfg.fin_to  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: step times from the configuration, request rides along.
  logic       tv;
  rtb_times_t tm;

  rtb_steps u_steps (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (req.valid),
    .in_req    (req.requested_budget_us),
    .cfg       (cfg),
    .out_valid (tv),
    .out_times (tm)
  );

  // The user keeps configuration stable while words are in flight; the block
  // does not enforce it. Enable bits are read straight from the registers at every stage.
  logic en_tcc, en_dss, en_msrc, en_pre, en_fin;
  assign en_tcc  = cfg.seq[SEQ_TCC];
  assign en_dss  = cfg.seq[SEQ_DSS];
  assign en_msrc = cfg.seq[SEQ_MSRC];
  assign en_pre  = cfg.seq[SEQ_PRE];
  assign en_fin  = cfg.seq[SEQ_FIN];

  // Budget stage 1: sum the enabled step costs and the reported budget.
  logic [BUD_W-1:0] steps_next, bud_next, msrc32, pre32, fin32;

  always_comb begin
    msrc32 = BUD_W'(tm.msrc_us);
    pre32  = BUD_W'(tm.pre_us);
    fin32  = BUD_W'(tm.fin_us);
    steps_next = '0;
    if (en_tcc) steps_next = steps_next + msrc32 + COST_TCC;
    if (en_dss) steps_next = steps_next + ((msrc32 + COST_DSS) << 1);
    else if (en_msrc) steps_next = steps_next + msrc32 + COST_MSRC;
    if (en_pre) steps_next = steps_next + pre32 + COST_PRE;
    bud_next = START_GET + steps_next;
    if (en_fin) bud_next = bud_next + fin32 + COST_FIN;
  end

  logic              b1v;
  logic [BUD_W-1:0]  b1_steps, b1_bud;
  logic [REQ_W-1:0]  b1_req;
  logic [CODE_W-1:0] b1_pre_m;
  logic [NS_W-1:0]   b1_ns;

  always_ff @(posedge clk) begin
    if (rst) b1v <= 1'b0;
    else if (adv) b1v <= tv;
    if (adv) begin
      b1_steps <= steps_next;
      b1_bud   <= bud_next;
      b1_req   <= tm.req;
      b1_pre_m <= tm.pre_m;
      b1_ns    <= tm.ns_fin;
    end
  end

  // Budget stage 2: used time, feasibility and the divider numerator.
  logic [BUD_W-1:0] used, req32, num_next, prod1000;
  logic             big, over;

  always_comb begin
    req32 = BUD_W'(b1_req);
    used  = START_SET + b1_steps + (en_fin ? COST_FIN : '0);
    big   = req32 >= BUDGET_MIN;
    over  = used > req32;
    prod1000 = (req32 - used) * 32'd1000;
    num_next = prod1000 + BUD_W'(b1_ns >> 1);
  end

  logic             b2v;
  logic [DIV_W-1:0] b2_num;
  logic [NS_W-1:0]  b2_ns;
  rtb_side_t        b2_side;

  always_ff @(posedge clk) begin
    if (rst) b2v <= 1'b0;
    else if (adv) b2v <= b1v;
    if (adv) begin
      b2_num         <= num_next;
      b2_ns          <= b1_ns;
      b2_side.budget <= b1_bud;
      b2_side.ok     <= big && !(en_fin && over);
      b2_side.wr     <= big && en_fin && !over;
      b2_side.pre_m  <= b1_pre_m;
    end
  end

  // Microseconds to macro clocks. A zero period gives an all-ones quotient.
  logic             dv;
  logic [DIV_W-1:0] quo;
  rtb_side_t        dside;

  rtb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (b2v),
    .in_num    (b2_num),
    .in_den    (b2_ns),
    .in_side   (b2_side),
    .out_valid (dv),
    .out_quo   (quo),
    .out_side  (dside)
  );

  // Add back the pre-range share, encode, and load the output register.
  logic [CODE_W-1:0] mclk_next;

  always_comb begin
    mclk_next = quo[CODE_W-1:0];
    if (en_pre) mclk_next = mclk_next + dside.pre_m;
  end

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (adv) res.valid <= dv;
    if (adv) begin
      res.current_budget_us <= dside.budget;
      res.accepted          <= dside.ok;
      res.timeout_valid     <= dside.wr;
      res.new_final_code    <= dside.wr ? encode_code(mclk_next) : '0;
    end
  end

endmodule
